@@ rtl/scf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

   // Q1.16 register values, 65536 meaning 1.0
   localparam int POS_W = 17;
   // Smoothed position and fades, Q1.24
   localparam int FADE_W = 25;
   // Gains, Q1.16
   localparam int GAIN_W = 17;

   localparam logic [POS_W-1:0]  POS_ONE   = 17'd65536;
   localparam logic [FADE_W-1:0] FADE_ONE  = 25'd16777216;
   localparam logic [FADE_W-1:0] FADE_HALF = 25'd8388608;

   // One-pole smoothing coefficient, 0.001 in Q0.24
   localparam logic [14:0] SMOOTH_COEF = 15'd16777;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CURVE  = 2'd2;

   // log2(1 + i/16) in Q16
   function automatic logic [16:0] log2_entry(input logic [4:0] idx);
      logic [16:0] val;
      case (idx)
         5'd0:    val = 17'd0;
         5'd1:    val = 17'd5732;
         5'd2:    val = 17'd11136;
         5'd3:    val = 17'd16248;
         5'd4:    val = 17'd21098;
         5'd5:    val = 17'd25711;
         5'd6:    val = 17'd30109;
         5'd7:    val = 17'd34312;
         5'd8:    val = 17'd38336;
         5'd9:    val = 17'd42196;
         5'd10:   val = 17'd45904;
         5'd11:   val = 17'd49472;
         5'd12:   val = 17'd52911;
         5'd13:   val = 17'd56229;
         5'd14:   val = 17'd59434;
         5'd15:   val = 17'd62534;
         default: val = 17'd65536;
      endcase
      return val;
   endfunction

   // 2^(i/16) in Q16
   function automatic logic [17:0] exp2_entry(input logic [4:0] idx);
      logic [17:0] val;
      case (idx)
         5'd0:    val = 18'd65536;
         5'd1:    val = 18'd68438;
         5'd2:    val = 18'd71468;
         5'd3:    val = 18'd74632;
         5'd4:    val = 18'd77936;
         5'd5:    val = 18'd81386;
         5'd6:    val = 18'd84990;
         5'd7:    val = 18'd88752;
         5'd8:    val = 18'd92682;
         5'd9:    val = 18'd96785;
         5'd10:   val = 18'd101070;
         5'd11:   val = 18'd105545;
         5'd12:   val = 18'd110218;
         5'd13:   val = 18'd115098;
         5'd14:   val = 18'd120194;
         5'd15:   val = 18'd125515;
         default: val = 18'd131072;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ rtl/stereo_crossfader_smoothed_curve.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A disabled block passes source A through S_OUT to the response register. Otherwise a
// request runs through S_DIFF, S_STEP, S_FADE, S_GAIN, S_MIX and S_OUT; with a nonzero
// curve S_GAIN waits for the normalization steps in each gain lane. One request is in
// flight at a time: a new audio request is taken only once the last one has left S_OUT.
// Snap requests give no response and leave the block idle. Synchronous active-high reset
// restores enable=1, target=0.5, curve=0 and a smoothed position of one half.
module stereo_crossfader_smoothed_curve import scf_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata, from bit 0 up: a_left, a_right, b_left, b_right, zero padding
   input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: kind (0 audio frame, 1 snap position to target)
   input  wire logic [0:0]                        req_tuser,
   // Response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata, from bit 0 up: mix_left, mix_right, zero padding
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   // Register write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [CSR_IDX_W-1:0]              csr_index,
   input  wire logic [POS_W-1:0]                  csr_wdata
);

   localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIFF = 3'd1;
   localparam logic [2:0] S_STEP = 3'd2;
   localparam logic [2:0] S_FADE = 3'd3;
   localparam logic [2:0] S_GAIN = 3'd4;
   localparam logic [2:0] S_MIX  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]              state_ff, state_in;

   // Registers
   logic                    enable_ff;
   logic [POS_W-1:0]        target_ff;
   logic [POS_W-1:0]        curve_ff;
   logic [POS_W-1:0]        csr_clamped;

   // Smoothed fader position, Q1.24
   logic [FADE_W-1:0]       pos_ff, pos_in;
   logic [FADE_W-1:0]       tgt_q24;
   logic signed [FADE_W:0]  pos_diff;
   logic signed [40:0]      smooth_ff, smooth_in;
   logic [40:0]             smooth_mag;
   logic [40:0]             smooth_rnd;
   logic [FADE_W-1:0]       smooth_step;

   // Held request
   logic                    pass_ff, pass_in;
   logic signed [SAMPLE_BITS-1:0] al_ff, ar_ff, bl_ff, br_ff;

   // Fades and lane handshakes
   logic [FADE_W-1:0]       fa_half;
   logic [FADE_W:0]         fa_raw, fb_raw;
   logic [FADE_W-1:0]       fade_a, fade_b;
   logic                    lane_start;
   logic                    ready_a, ready_b;
   logic [GAIN_W-1:0]       gain_a, gain_b;
   logic                    mix_start, mix_done;
   logic [SAMPLE_BITS-1:0]  mix_l, mix_r;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  rsp_l_ff, rsp_r_ff;
   logic                    rsp_load;

   logic                    req_fire;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Out-of-range target and curve values pin to 1.0
   assign csr_clamped = (csr_wdata > POS_ONE) ? POS_ONE : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         target_ff <= POS_W'(32768);
         curve_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ENABLE: enable_ff <= csr_wdata[0];
            REG_TARGET: target_ff <= csr_clamped;
            REG_CURVE:  curve_ff  <= csr_clamped;
            default: begin
            end
         endcase
      end
   end

   // One-pole smoothing: step = round((target - pos) * coef / 2^24), ties away
   // from zero. The product is registered before the rounding and update.
   always_comb begin
      tgt_q24     = {target_ff, 8'd0};
      pos_diff    = $signed({1'b0, tgt_q24}) - $signed({1'b0, pos_ff});
      smooth_in   = pos_diff * $signed({1'b0, SMOOTH_COEF});
      smooth_mag  = smooth_ff[40] ? 41'(-smooth_ff) : 41'(smooth_ff);
      smooth_rnd  = smooth_mag + 41'd8388608;
      smooth_step = FADE_W'(smooth_rnd[40:24]);
   end

   // Fade A = min(1, 2(1-p)), fade B = min(1, 2p)
   always_comb begin
      fa_half = FADE_ONE - pos_ff;
      fa_raw  = {fa_half, 1'b0};
      fb_raw  = {pos_ff, 1'b0};
      fade_a  = (fa_raw > {1'b0, FADE_ONE}) ? FADE_ONE : fa_raw[FADE_W-1:0];
      fade_b  = (fb_raw > {1'b0, FADE_ONE}) ? FADE_ONE : fb_raw[FADE_W-1:0];
   end

   assign lane_start = (state_ff == S_FADE);
   assign mix_start  = (state_ff == S_GAIN) && ready_a && ready_b;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      pass_in  = pass_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0]) begin
                  // Snap request: jump to the target, no response
                  pos_in = tgt_q24;
               end else if (!enable_ff) begin
                  pass_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  pass_in  = 1'b0;
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF: state_in = S_STEP;
         S_STEP: begin
            pos_in   = smooth_ff[40] ? pos_ff - smooth_step : pos_ff + smooth_step;
            state_in = S_FADE;
         end
         S_FADE: state_in = S_GAIN;
         S_GAIN: begin
            if (mix_start) begin
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            if (mix_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= FADE_HALF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff   <= pass_in;
      smooth_ff <= smooth_in;
      if (req_fire) begin
         al_ff <= req_tdata[SAMPLE_BITS-1:0];
         ar_ff <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         bl_ff <= req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
         br_ff <= req_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
      end
      if (rsp_load) begin
         rsp_l_ff <= pass_ff ? al_ff : mix_l;
         rsp_r_ff <= pass_ff ? ar_ff : mix_r;
      end
   end

   // Two gain lanes run side by side, one per source
   scf_gain_lane u_lane_a (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .fade  (fade_a),
      .curve (curve_ff),
      .ready (ready_a),
      .gain  (gain_a)
   );

   scf_gain_lane u_lane_b (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .fade  (fade_b),
      .curve (curve_ff),
      .ready (ready_b),
      .gain  (gain_b)
   );

   scf_mix #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .start     (mix_start),
      .a_left    (al_ff),
      .a_right   (ar_ff),
      .b_left    (bl_ff),
      .b_right   (br_ff),
      .gain_a    (gain_a),
      .gain_b    (gain_b),
      .done      (mix_done),
      .mix_left  (mix_l),
      .mix_right (mix_r)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_r_ff, rsp_l_ff});

endmodule

`default_nettype wire

@@ rtl/scf_gain_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Turns one fade into a gain, either linearly or through the log2/exp2 power curve.
module scf_gain_lane import scf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [FADE_W-1:0] fade,
   input  wire logic [POS_W-1:0]  curve,
   output logic                   ready,
   output logic [GAIN_W-1:0]      gain
);

   localparam logic [2:0] L_IDLE  = 3'd0;
   localparam logic [2:0] L_NORM  = 3'd1;
   localparam logic [2:0] L_LOG   = 3'd2;
   localparam logic [2:0] L_POW   = 3'd3;
   localparam logic [2:0] L_EXP   = 3'd4;
   localparam logic [2:0] L_SHIFT = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [FADE_W-1:0] mant_ff, mant_in;
   logic [4:0]        z_ff, z_in;
   logic [20:0]       nl_ff, nl_in;
   logic [22:0]       n_ff, n_in;
   logic [17:0]       r_ff, r_in;
   logic [4:0]        q_ff, q_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;

   logic [FADE_W:0]   lin_sum;
   logic [4:0]        log_i;
   logic [16:0]       log_lo, log_hi;
   logic [12:0]       log_diff;
   logic [32:0]       log_prod;
   logic [16:0]       lg;
   logic [17:0]       expo;
   logic [38:0]       pow_sum;
   logic [6:0]        q_full;
   logic [16:0]       g;
   logic [4:0]        exp_j;
   logic [17:0]       exp_lo, exp_hi;
   logic [12:0]       exp_diff;
   logic [24:0]       exp_prod;
   logic [18:0]       sh_sum;
   logic [18:0]       sh_val;

   always_comb begin
      lin_sum  = {1'b0, fade} + (FADE_W+1)'(128);

      // Mantissa in [1,2): table index from the top four fraction bits
      log_i    = {1'b0, mant_ff[23:20]};
      log_lo   = log2_entry(log_i);
      log_hi   = log2_entry(log_i + 5'd1);
      log_diff = 13'(log_hi - log_lo);
      log_prod = log_diff * mant_ff[19:0];
      lg       = log_lo + 17'(log_prod[32:20]);

      expo     = 18'd65536 + {curve, 1'b0};
      pow_sum  = 39'(nl_ff * expo) + 39'd32768;

      q_full   = n_ff[22:16];
      g        = 17'd65536 - {1'b0, n_ff[15:0]};
      exp_j    = g[16:12];
      exp_lo   = exp2_entry(exp_j);
      exp_hi   = exp2_entry(exp_j + 5'd1);
      exp_diff = 13'(exp_hi - exp_lo);
      exp_prod = exp_diff * g[11:0];

      sh_sum   = {1'b0, r_ff} + (19'd1 << q_ff);
      sh_val   = sh_sum >> (q_ff + 5'd1);
   end

   always_comb begin
      state_in = state_ff;
      mant_in  = mant_ff;
      z_in     = z_ff;
      nl_in    = nl_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      gain_in  = gain_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               if (curve == '0) begin
                  gain_in = lin_sum[FADE_W-1:8];
               end else if (fade == '0) begin
                  gain_in = '0;
               end else begin
                  mant_in  = fade;
                  z_in     = '0;
                  state_in = L_NORM;
               end
            end
         end
         L_NORM: begin
            // Coarse steps of eight while the top byte is empty, then single bits
            if (mant_ff[FADE_W-1]) begin
               state_in = L_LOG;
            end else if (mant_ff[FADE_W-1:FADE_W-8] == '0) begin
               mant_in = mant_ff << 8;
               z_in    = z_ff + 5'd8;
            end else begin
               mant_in = mant_ff << 1;
               z_in    = z_ff + 5'd1;
            end
         end
         L_LOG: begin
            nl_in    = {z_ff, 16'd0} - {4'd0, lg};
            state_in = L_POW;
         end
         L_POW: begin
            n_in     = pow_sum[38:16];
            state_in = L_EXP;
         end
         L_EXP: begin
            if (q_full > 7'd17) begin
               gain_in  = '0;
               state_in = L_IDLE;
            end else begin
               q_in     = q_full[4:0];
               r_in     = g[16] ? exp2_entry(5'd16) : exp_lo + 18'(exp_prod[24:12]);
               state_in = L_SHIFT;
            end
         end
         L_SHIFT: begin
            gain_in  = sh_val[GAIN_W-1:0];
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mant_ff <= mant_in;
      z_ff    <= z_in;
      nl_ff   <= nl_in;
      n_ff    <= n_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      gain_ff <= gain_in;
   end

   assign ready = (state_ff == L_IDLE);
   assign gain  = gain_ff;

endmodule

`default_nettype wire

@@ rtl/scf_mix.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Merges the two lane gains: a*gain_a + b*gain_b per channel, rounded and saturated.
module scf_mix import scf_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [SAMPLE_BITS-1:0] a_left,
   input  wire logic signed [SAMPLE_BITS-1:0] a_right,
   input  wire logic signed [SAMPLE_BITS-1:0] b_left,
   input  wire logic signed [SAMPLE_BITS-1:0] b_right,
   input  wire logic        [GAIN_W-1:0]      gain_a,
   input  wire logic        [GAIN_W-1:0]      gain_b,
   output logic                               done,
   output logic             [SAMPLE_BITS-1:0] mix_left,
   output logic             [SAMPLE_BITS-1:0] mix_right
);

   localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int SH_W   = SUM_W - 16;

   logic                          v1_ff, done_ff;
   logic signed [PROD_W-1:0]      pal_ff, par_ff, pbl_ff, pbr_ff;
   logic signed [SUM_W-1:0]       sum_l, sum_r;
   logic        [SAMPLE_BITS-1:0] mix_l_ff, mix_r_ff;
   logic signed [GAIN_W:0]        ga_s, gb_s;

   function automatic logic [SAMPLE_BITS-1:0] saturate(input logic [SH_W-1:0] v);
      logic [SH_W-SAMPLE_BITS:0] upper;
      logic [SAMPLE_BITS-1:0]    res;
      upper = v[SH_W-1:SAMPLE_BITS-1];
      if ((&upper) || !(|upper)) begin
         res = v[SAMPLE_BITS-1:0];
      end else if (v[SH_W-1]) begin
         res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return res;
   endfunction

   assign ga_s = $signed({1'b0, gain_a});
   assign gb_s = $signed({1'b0, gain_b});

   always_comb begin
      sum_l = SUM_W'(pal_ff) + SUM_W'(pbl_ff) + SUM_W'(32768);
      sum_r = SUM_W'(par_ff) + SUM_W'(pbr_ff) + SUM_W'(32768);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         done_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pal_ff <= a_left * ga_s;
         par_ff <= a_right * ga_s;
         pbl_ff <= b_left * gb_s;
         pbr_ff <= b_right * gb_s;
      end
      if (v1_ff) begin
         // Arithmetic shift by 16 is the floor of the division
         mix_l_ff <= saturate(sum_l[SUM_W-1:16]);
         mix_r_ff <= saturate(sum_r[SUM_W-1:16]);
      end
   end

   assign done      = done_ff;
   assign mix_left  = mix_l_ff;
   assign mix_right = mix_r_ff;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Testbench for the stereo crossfader with a smoothed fader position and a
// power-shaped fade curve. Requests carry one stereo frame from each source,
// or a snap command that jumps the smoothed position to the target. A
// behavioral predictor keeps its own copy of the registers and of the smoothed
// position and computes the mixed frame for every accepted audio request.
// The expected frames wait in a queue and are compared with the responses in
// order. Both sides of the stream idle at random. Once, the response side holds
// off for a long stretch so that the block fills up and stalls its requests.
module testbench;
   import scf_pkg::*;

   localparam int SAMPLE_W = 24;
   localparam int REQ_W = ((4*SAMPLE_W+7)/8)*8;
   localparam int RSP_W = ((2*SAMPLE_W+7)/8)*8;

   // Snap requests give no response, so settle waits out this pause after the
   // last response before touching a register.
   localparam int LATENCY_PAUSE = 24;
   // How long the response side refuses responses during the stall test.
   localparam int HOLD_CYCLES = 300;
   // Cycles without any handshake before the run is declared hung. This
   // covers the long hold-off above plus the longest random gaps.
   localparam int QUIET_LIMIT = 5000;
   localparam int GAP_PERCENT = 37;

   localparam longint Q24_ONE = 64'sd16777216;
   localparam longint GLIDE_COEF = 64'sd16777;
   localparam logic [POS_W-1:0] REG_VALUE_MAX = 17'h1FFFF;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum logic {
      KIND_AUDIO = 1'b0,
      KIND_SNAP  = 1'b1
   } req_kind_e;

   // One request: the kind and the four samples.
   typedef struct packed {
      req_kind_e           kind;
      logic signed [23:0]  a_left;
      logic signed [23:0]  a_right;
      logic signed [23:0]  b_left;
      logic signed [23:0]  b_right;
   } frame_t;

   // One mixed frame, laid out as in rsp_tdata: left in the low bits.
   typedef struct packed {
      logic signed [23:0]  right;
      logic signed [23:0]  left;
   } stereo_t;

   logic clock = 1'b0;
   logic reset;

   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic [0:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [POS_W-1:0]  csr_wdata;

   stereo_crossfader_smoothed_curve #(
      .SAMPLE_BITS (SAMPLE_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Predictor state: the registers as the block holds them after clamping,
   // and the smoothed fader position in Q1.24.
   logic    mix_enabled;
   int      fader_target;
   int      curve_depth;
   longint  glide_pos;

   stereo_t expected_mix[$];
   int      mismatch_count;

   // While set, neither side idles.
   bit      steady_flow;
   // The stall test bumps this; the response side notices and holds off.
   int      holdoff_requested;
   int      holdoff_taken;
   int      hold_left;
   int      quiet_cycles;

   stereo_t got_mix;
   stereo_t want_mix;

   function automatic bit take_gap();
      return !steady_flow && ($urandom_range(0, 99) < GAP_PERCENT);
   endfunction

   function automatic void note_failure(string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", what);
      end
   endfunction

   // log2(1 + idx/16) in Q16.
   function automatic longint log2_point(longint idx);
      case (idx)
         0:       return 0;
         1:       return 5732;
         2:       return 11136;
         3:       return 16248;
         4:       return 21098;
         5:       return 25711;
         6:       return 30109;
         7:       return 34312;
         8:       return 38336;
         9:       return 42196;
         10:      return 45904;
         11:      return 49472;
         12:      return 52911;
         13:      return 56229;
         14:      return 59434;
         15:      return 62534;
         default: return 65536;
      endcase
   endfunction

   // 2^(idx/16) in Q16.
   function automatic longint exp2_point(longint idx);
      case (idx)
         0:       return 65536;
         1:       return 68438;
         2:       return 71468;
         3:       return 74632;
         4:       return 77936;
         5:       return 81386;
         6:       return 84990;
         7:       return 88752;
         8:       return 92682;
         9:       return 96785;
         10:      return 101070;
         11:      return 105545;
         12:      return 110218;
         13:      return 115098;
         14:      return 120194;
         15:      return 125515;
         default: return 131072;
      endcase
   endfunction

   // Turns a Q1.24 fade into a Q1.16 gain. Without a curve the fade is just
   // rounded. With a curve the fade is raised to the power 1 + 2*curve: the
   // negative log2 of the fade is scaled by the exponent and then turned back
   // through the exp2 table, split into a whole shift and a fraction.
   function automatic longint fade_to_gain(longint fade);
      int      msb;
      int      whole;
      longint  expo, norm, frac, seg, rem, log_m, neg_log, scaled, part, root;
      if (curve_depth == 0) begin
         return (fade + 128) >>> 8;
      end
      // A silent fade has no logarithm; its gain is simply zero.
      if (fade <= 0) begin
         return 0;
      end
      expo = 65536 + 2 * longint'(curve_depth);
      msb = 24;
      while (msb > 0 && ((fade >>> msb) & 1) == 0) begin
         msb--;
      end
      norm = fade << (24 - msb);
      frac = norm - Q24_ONE;
      seg = frac >>> 20;
      rem = frac & 64'h000F_FFFF;
      log_m = log2_point(seg)
            + (((log2_point(seg + 1) - log2_point(seg)) * rem) >>> 20);
      neg_log = longint'(24 - msb) * 65536 - log_m;
      scaled = (neg_log * expo + 32768) >>> 16;
      whole = int'(scaled >>> 16);
      // Very small fades shift the gain out completely.
      if (whole > 17) begin
         return 0;
      end
      part = 65536 - (scaled & 65535);
      seg = part >>> 12;
      if (seg >= 16) begin
         root = exp2_point(16);
      end else begin
         rem = part & 64'hFFF;
         root = exp2_point(seg)
              + (((exp2_point(seg + 1) - exp2_point(seg)) * rem) >>> 12);
      end
      return (root + (64'sd1 << whole)) >>> (whole + 1);
   endfunction

   function automatic logic signed [23:0] clip_sample(longint v);
      if (v > 64'sd8388607) begin
         return 24'sh7FFFFF;
      end
      if (v < -64'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   // Called for every accepted request. A snap only moves the smoothed
   // position. When mixing is off, source A goes through and the position
   // stays put. Otherwise the position takes one smoothing step before the
   // fades are derived from it.
   function automatic void predict_mix(frame_t f);
      longint  tgt_q24, diff, mag, step, fade_a, fade_b, gain_a, gain_b;
      stereo_t mix;
      tgt_q24 = longint'(fader_target) << 8;
      if (f.kind == KIND_SNAP) begin
         glide_pos = tgt_q24;
         return;
      end
      if (!mix_enabled) begin
         mix.left = f.a_left;
         mix.right = f.a_right;
         expected_mix.push_back(mix);
         return;
      end
      // The step is rounded on its magnitude, so ties go away from zero.
      diff = (tgt_q24 - glide_pos) * GLIDE_COEF;
      mag = (diff < 0) ? -diff : diff;
      step = (mag + (64'sd1 << 23)) >>> 24;
      glide_pos += (diff < 0) ? -step : step;
      fade_a = 2 * (Q24_ONE - glide_pos);
      if (fade_a > Q24_ONE) begin
         fade_a = Q24_ONE;
      end
      fade_b = 2 * glide_pos;
      if (fade_b > Q24_ONE) begin
         fade_b = Q24_ONE;
      end
      gain_a = fade_to_gain(fade_a);
      gain_b = fade_to_gain(fade_b);
      // The arithmetic shift floors, which is the rounding the block uses.
      mix.left = clip_sample((longint'(f.a_left) * gain_a
                            + longint'(f.b_left) * gain_b + 32768) >>> 16);
      mix.right = clip_sample((longint'(f.a_right) * gain_a
                             + longint'(f.b_right) * gain_b + 32768) >>> 16);
      expected_mix.push_back(mix);
   endfunction

   function automatic frame_t make_frame(req_kind_e kind, logic signed [23:0] al,
                                         logic signed [23:0] ar,
                                         logic signed [23:0] bl,
                                         logic signed [23:0] br);
      frame_t f;
      f.kind = kind;
      f.a_left = al;
      f.a_right = ar;
      f.b_left = bl;
      f.b_right = br;
      return f;
   endfunction

   // Mostly full-range samples, with the extremes and values near zero
   // mixed in so that saturation and rounding both get exercised.
   function automatic logic signed [23:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 24'sh7FFFFF;
         1:       return 24'sh800000;
         2:       return 24'($urandom_range(0, 511)) - 24'd256;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic frame_t random_frame(bit allow_snap);
      req_kind_e kind;
      kind = (allow_snap && $urandom_range(0, 99) < 6) ? KIND_SNAP : KIND_AUDIO;
      return make_frame(kind, pick_sample(), pick_sample(), pick_sample(),
                        pick_sample());
   endfunction

   // All tasks below start and end right after a falling edge, so inputs
   // change only there and every signal gets one assignment per step.
   task automatic send_request(frame_t f);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {f.b_right, f.b_left, f.a_right, f.a_left};
      req_tuser <= f.kind;
      do begin
         @(posedge clock);
      end while (!req_tready);
      predict_mix(f);
      @(negedge clock);
   endtask

   // Register writes mirror the clamping that the block applies: enable
   // keeps only its low bit, target and curve saturate at one, and an
   // unknown index changes nothing.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [POS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         REG_ENABLE: mix_enabled = value[0];
         REG_TARGET: fader_target = (value > POS_ONE) ? int'(POS_ONE) : int'(value);
         REG_CURVE:  curve_depth = (value > POS_ONE) ? int'(POS_ONE) : int'(value);
         default:    ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stops offering requests and waits until every expected response has
   // arrived, then lets the latency pass in case a snap is still in flight.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_mix.size() != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY_PAUSE) @(negedge clock);
   endtask

   task automatic configure(logic [POS_W-1:0] en, logic [POS_W-1:0] tgt,
                            logic [POS_W-1:0] crv);
      settle();
      write_register(REG_ENABLE, en);
      write_register(REG_TARGET, tgt);
      write_register(REG_CURVE, crv);
   endtask

   // Reset state: mixing on, target one half, linear fades. At one half both
   // fades are full, so two full-scale sources must saturate.
   task automatic test_default_mix();
      send_request(make_frame(KIND_AUDIO, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
      send_request(make_frame(KIND_AUDIO, 24'sh7FFFFF, 24'sh7FFFFF,
                              24'sh7FFFFF, 24'sh7FFFFF));
      send_request(make_frame(KIND_AUDIO, 24'sh800000, 24'sh800000,
                              24'sh800000, 24'sh800000));
      send_request(make_frame(KIND_AUDIO, 24'sh7FFFFF, 24'sh800000,
                              24'sh800000, 24'sh7FFFFF));
      send_request(random_frame(1'b0));
   endtask

   // Out-of-range register values, an unknown index, the fader at both ends
   // where one fade is zero, a fade so small that the curve removes it, and
   // snaps while mixing is off.
   task automatic test_register_limits();
      settle();
      write_register(REG_CURVE, REG_VALUE_MAX);
      write_register(REG_TARGET, REG_VALUE_MAX);
      write_register(REG_UNUSED, 17'($urandom));
      send_request(make_frame(KIND_SNAP, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
      send_request(make_frame(KIND_AUDIO, 24'sh7FFFFF, 24'sh800000,
                              24'sh7FFFFF, 24'sh800000));
      send_request(random_frame(1'b0));
      settle();
      write_register(REG_TARGET, '0);
      send_request(make_frame(KIND_SNAP, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
      send_request(make_frame(KIND_AUDIO, 24'sh800000, 24'sh7FFFFF,
                              24'sh800000, 24'sh7FFFFF));
      settle();
      write_register(REG_TARGET, 17'd1);
      send_request(make_frame(KIND_SNAP, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
      send_request(random_frame(1'b0));
      send_request(random_frame(1'b0));
      settle();
      // Only the low bit of enable counts, so 2 turns mixing off.
      write_register(REG_ENABLE, 17'd2);
      send_request(make_frame(KIND_AUDIO, 24'sh7FFFFF, 24'sh800000,
                              24'sh800000, 24'sh7FFFFF));
      send_request(make_frame(KIND_AUDIO, 24'sh800000, 24'sh7FFFFF,
                              24'sh7FFFFF, 24'sh800000));
      settle();
      write_register(REG_TARGET, 17'd49152);
      // The snap still moves the position while mixing is off.
      send_request(make_frame(KIND_SNAP, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
      settle();
      write_register(REG_CURVE, '0);
      write_register(REG_ENABLE, REG_VALUE_MAX);
      send_request(random_frame(1'b0));
      send_request(random_frame(1'b0));
   endtask

   // Random frames under a series of settings, the extremes first. Half of
   // the phases open with a snap so that the fader reaches its target range
   // at once instead of crawling toward it.
   task automatic test_random_phases();
      logic [POS_W-1:0] en, tgt, crv;
      for (int phase = 0; phase < 10; phase++) begin
         en = 17'd1;
         case (phase)
            0: begin
               tgt = '0;
               crv = '0;
            end
            1: begin
               tgt = POS_ONE;
               crv = POS_ONE;
            end
            2: begin
               tgt = REG_VALUE_MAX;
               crv = 17'd1;
            end
            3: begin
               en = 17'($urandom) & ~17'd1;
               tgt = 17'($urandom);
               crv = 17'($urandom);
            end
            4: begin
               tgt = 17'($urandom_range(0, 64));
               crv = POS_ONE;
            end
            5: begin
               tgt = POS_ONE - 17'($urandom_range(0, 64));
               crv = 17'($urandom);
            end
            default: begin
               en = ($urandom_range(0, 5) == 0) ? 17'($urandom) : 17'd1;
               case ($urandom_range(0, 2))
                  0:       tgt = 17'($urandom);
                  1:       tgt = 17'($urandom_range(0, 1024));
                  default: tgt = 17'($urandom_range(0, 65536));
               endcase
               crv = ($urandom_range(0, 3) == 0) ? '0 : 17'($urandom);
            end
         endcase
         configure(en, tgt, crv);
         // One phase runs with no idling on either side at all.
         steady_flow = (phase == 4);
         if (phase % 2 == 0) begin
            send_request(make_frame(KIND_SNAP, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
         end
         repeat (140) send_request(random_frame(1'b1));
         steady_flow = 1'b0;
      end
   endtask

   // The response side refuses for a long stretch while requests keep
   // coming; the block must fill up and stall its input without losing or
   // reordering anything.
   task automatic test_response_stall();
      configure(17'd1, 17'($urandom_range(0, 65536)), 17'($urandom_range(1, 65536)));
      steady_flow = 1'b1;
      holdoff_requested++;
      repeat (40) send_request(random_frame(1'b0));
      steady_flow = 1'b0;
   endtask

   // Response side: random back-pressure, or a long refusal when asked.
   always @(negedge clock) begin
      if (holdoff_taken != holdoff_requested) begin
         holdoff_taken = holdoff_requested;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !take_gap();
      end
   end

   // Each accepted response is matched against the oldest expected frame.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_mix = rsp_tdata;
         if (expected_mix.size() == 0) begin
            note_failure($sformatf("unexpected response L=%0d R=%0d",
                                   got_mix.left, got_mix.right));
         end else begin
            want_mix = expected_mix.pop_front();
            if (got_mix.left !== want_mix.left) begin
               note_failure($sformatf("mix_left mismatch: expected %0d, got %0d",
                                      want_mix.left, got_mix.left));
            end
            if (got_mix.right !== want_mix.right) begin
               note_failure($sformatf("mix_right mismatch: expected %0d, got %0d",
                                      want_mix.right, got_mix.right));
            end
         end
      end
   end

   // A run that stops making progress ends here.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[stereo_crossfader_smoothed_curve] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      steady_flow = 1'b0;
      holdoff_requested = 0;
      holdoff_taken = 0;
      hold_left = 0;
      quiet_cycles = 0;
      mix_enabled = 1'b1;
      fader_target = 32768;
      curve_depth = 0;
      glide_pos = 64'sd8388608;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_mix();
      test_register_limits();
      test_random_phases();
      test_response_stall();
      settle();

      if (mismatch_count == 0 && expected_mix.size() == 0) begin
         $display("[stereo_crossfader_smoothed_curve] OK");
      end else begin
         $display("[stereo_crossfader_smoothed_curve] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/scf_pkg.sv
rtl/scf_gain_lane.sv
rtl/scf_mix.sv
rtl/stereo_crossfader_smoothed_curve.sv
bench/testbench.sv
